FILE: rtl/core/aatq_pkg.sv
// Shared types, constants and helpers for the rotation vector to quaternion pipeline.
`default_nettype none

package aatq_pkg;

  localparam int SQRT_STEPS   = 32;
  localparam int SERIES_TERMS = 10;
  localparam int STEP_STAGES  = 4;
  localparam int SERIES_DEPTH = SERIES_TERMS * STEP_STAGES + 2;
  localparam int QUOT_W       = 16;
  localparam int QUOT_DEPTH   = QUOT_W + 3;

  localparam logic [31:0] ONE_Q30      = 32'd1073741824;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
  localparam logic [29:0] HALF_LSB_Q30 = 30'h2000_0000;
  localparam logic [15:0] OUT_MAX      = 16'd16384;

  // per-word sideband; fields are filled in as the word moves down the pipe
  typedef struct packed {
    logic               zero;
    logic               neg;
    logic        [31:0] t;
    logic signed [31:0] hr;
    logic        [31:0] u;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
  } side_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  // unsigned v * 2^-30, round half up; callers keep the result below 2^32
  function automatic logic [31:0] round_q30(input logic [63:0] v);
    logic [64:0] s;
    s = 65'(v) + 65'(HALF_LSB_Q30);
    return s[61:30];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aatq_sqrt.sv
// Sum of squares and a one-bit-per-stage integer square root giving theta.
`default_nettype none

module aatq_sqrt (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  wire signed   [15:0] in_x,
  input  wire signed   [15:0] in_y,
  input  wire signed   [15:0] in_z,
  output logic                out_valid,
  output aatq_pkg::side_t     out_side
);

  localparam int N = aatq_pkg::SQRT_STEPS;

  logic [N:0]            v_q;
  logic [63:0]           rem_q  [0:N];
  logic [63:0]           res_q  [0:N];
  aatq_pkg::side_t       side_q [0:N];
  logic [63:0]           bitv   [0:N-1];
  logic [63:0]           trial  [0:N-1];
  logic [N-1:0]          take;
  logic signed [31:0]    sq_x, sq_y, sq_z;
  logic [31:0]           s2;

  assign sq_x = 32'(in_x) * 32'(in_x);
  assign sq_y = 32'(in_y) * 32'(in_y);
  assign sq_z = 32'(in_z) * 32'(in_z);
  assign s2   = sq_x + sq_y + sq_z;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      bitv[i]  = 64'd1 << (62 - 2 * i);
      trial[i] = res_q[i] + bitv[i];
      take[i]  = rem_q[i] >= trial[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= {s2, 32'd0};
      res_q[0]  <= '0;
      side_q[0] <= '{zero: (s2 == '0), cx: in_x, cy: in_y, cz: in_z, default: '0};
      for (int i = 0; i < N; i++) begin
        rem_q[i+1]  <= take[i] ? rem_q[i] - trial[i] : rem_q[i];
        res_q[i+1]  <= take[i] ? (res_q[i] >> 1) + bitv[i] : res_q[i] >> 1;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign out_valid = v_q[N];

  always_comb begin
    out_side   = side_q[N];
    out_side.t = res_q[N][31:0];
  end

endmodule

`default_nettype wire

FILE: rtl/core/aatq_prep.sv
// Half-angle range reduction and the squared argument for the series.
`default_nettype none

module aatq_prep (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  wire aatq_pkg::side_t in_side,
  output logic                out_valid,
  output aatq_pkg::side_t     out_side
);

  logic [2:0]       v_q;
  aatq_pkg::side_t  side_a_q, side_b_q, side_c_q;
  aatq_pkg::side_t  side_a_next, side_c_next;
  logic [61:0]      sq_b_q;
  logic [32:0]      diff;
  logic             fold;
  logic [31:0]      hr_neg;
  logic [30:0]      hr_mag;

  // past pi/2 the angle folds to pi - h and cos changes sign
  assign diff   = {1'b0, aatq_pkg::PI_Q30} - {1'b0, in_side.t};
  assign fold   = in_side.t > aatq_pkg::HALF_PI_Q30;
  assign hr_neg = 32'd0 - side_a_q.hr;
  assign hr_mag = side_a_q.hr[31] ? hr_neg[30:0] : side_a_q.hr[30:0];

  always_comb begin
    side_a_next     = in_side;
    side_a_next.neg = fold;
    side_a_next.hr  = fold ? diff[31:0] : in_side.t;
    side_c_next     = side_b_q;
    side_c_next.u   = aatq_pkg::round_q30(64'(sq_b_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a_q <= side_a_next;
      sq_b_q   <= 62'(hr_mag) * 62'(hr_mag);
      side_b_q <= side_a_q;
      side_c_q <= side_c_next;
    end
  end

  assign out_valid = v_q[2];
  assign out_side  = side_c_q;

endmodule

`default_nettype wire

FILE: rtl/core/aatq_series.sv
// Ten-term Horner series for cos and sin(x)/x, four stages per term, then sin.
`default_nettype none

module aatq_series (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  wire aatq_pkg::side_t in_side,
  output logic                out_valid,
  output aatq_pkg::side_t     out_side,
  output logic signed [31:0]  out_cs,
  output logic signed [31:0]  out_sn
);

  localparam int D = aatq_pkg::SERIES_DEPTH;
  localparam int T = aatq_pkg::SERIES_TERMS;
  localparam int S = aatq_pkg::STEP_STAGES;

  logic [D:1]          v_q;
  aatq_pkg::side_t     side_q    [1:D];
  logic signed [31:0]  c_res_q   [0:T-1];
  logic signed [31:0]  p_res_q   [0:T-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[D-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[1] <= in_side;
      for (int i = 2; i <= D; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // term k: X = 1 - R(X*u) / divisor, divide done as reciprocal multiply plus one fixup
  for (genvar j = 0; j < T; j++) begin : g_term
    localparam int K       = T - j;
    localparam int COS_DIV = (2 * K - 1) * (2 * K);
    localparam int SIN_DIV = (2 * K) * (2 * K + 1);
    localparam logic [31:0] COS_RECIP = 32'((64'd1 << 32) / COS_DIV);
    localparam logic [31:0] SIN_RECIP = 32'((64'd1 << 32) / SIN_DIV);

    logic [31:0] u_in;
    logic [30:0] c_in, p_in;
    logic [62:0] cprod_q, pprod_q;
    logic [31:0] cnum_q, pnum_q, cnum2_q, pnum2_q;
    logic [63:0] crec_q, prec_q;
    logic [31:0] cq_est, pq_est, crem, prem, cq, pq;
    logic [32:0] cnext, pnext;

    if (j == 0) begin : g_head
      assign u_in = in_side.u;
      assign c_in = aatq_pkg::ONE_Q30[30:0];
      assign p_in = aatq_pkg::ONE_Q30[30:0];
    end else begin : g_tail
      assign u_in = side_q[S*j].u;
      assign c_in = c_res_q[j-1][30:0];
      assign p_in = p_res_q[j-1][30:0];
    end

    always_comb begin
      cq_est = crec_q[63:32];
      pq_est = prec_q[63:32];
      crem   = cnum2_q - 32'(cq_est * 32'(COS_DIV));
      prem   = pnum2_q - 32'(pq_est * 32'(SIN_DIV));
      cq     = (crem >= 32'(COS_DIV)) ? cq_est + 32'd1 : cq_est;
      pq     = (prem >= 32'(SIN_DIV)) ? pq_est + 32'd1 : pq_est;
      cnext  = {1'b0, aatq_pkg::ONE_Q30} - {1'b0, cq};
      pnext  = {1'b0, aatq_pkg::ONE_Q30} - {1'b0, pq};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cprod_q    <= 63'(c_in) * 63'(u_in);
        pprod_q    <= 63'(p_in) * 63'(u_in);
        cnum_q     <= aatq_pkg::round_q30(64'(cprod_q));
        pnum_q     <= aatq_pkg::round_q30(64'(pprod_q));
        crec_q     <= 64'(cnum_q) * 64'(COS_RECIP);
        prec_q     <= 64'(pnum_q) * 64'(SIN_RECIP);
        cnum2_q    <= cnum_q;
        pnum2_q    <= pnum_q;
        c_res_q[j] <= cnext[31:0];
        p_res_q[j] <= pnext[31:0];
      end
    end
  end

  logic signed [63:0] fprod_q;
  logic signed [31:0] cs1_q, cs2_q, sn_q;
  logic [63:0]        fmag;
  logic [31:0]        fround;

  assign fmag   = fprod_q[63] ? 64'd0 - fprod_q : fprod_q;
  assign fround = aatq_pkg::round_q30(fmag);

  always_ff @(posedge clk) begin
    if (en) begin
      fprod_q <= 64'(p_res_q[T-1]) * 64'(side_q[S*T].hr);
      cs1_q   <= c_res_q[T-1];
      cs2_q   <= cs1_q;
      sn_q    <= fprod_q[63] ? 32'd0 - fround : fround;
    end
  end

  assign out_valid = v_q[D];
  assign out_side  = side_q[D];
  assign out_cs    = cs2_q;
  assign out_sn    = sn_q;

endmodule

`default_nettype wire

FILE: rtl/core/aatq_quot.sv
// Output scaling: w rounding and three pipelined restoring dividers by theta.
`default_nettype none

module aatq_quot (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  wire aatq_pkg::side_t in_side,
  input  wire signed   [31:0] in_cs,
  input  wire signed   [31:0] in_sn,
  output logic                out_valid,
  output aatq_pkg::quat_t     out_quat
);

  localparam int D  = aatq_pkg::QUOT_DEPTH;
  localparam int NW = aatq_pkg::QUOT_W;

  logic [D:1]            v_q;
  logic signed [15:0]    comp     [0:2];
  logic signed [47:0]    prod_q   [0:2];
  aatq_pkg::side_t       side1_q;
  logic [15:0]           w1_q;
  logic [47:0]           rem_q    [0:NW][0:2];
  logic [NW-1:0]         quo_q    [0:NW][0:2];
  logic [2:0]            sgn_q    [0:NW];
  logic [15:0]           wq_q     [0:NW];
  aatq_pkg::side_t       sided_q  [0:NW];
  logic [47:0]           dv       [0:NW-1];
  logic [2:0]            take     [0:NW-1];
  logic [47:0]           pmag     [0:2];
  logic [2:0]            pos;
  logic signed [31:0]    wv;
  logic [31:0]           wmag, wsum;
  aatq_pkg::quat_t       quat_q;

  function automatic logic [15:0] signed_out(input logic neg, input logic [15:0] mag);
    logic [15:0] m;
    m = (mag > aatq_pkg::OUT_MAX) ? aatq_pkg::OUT_MAX : mag;
    return neg ? 16'd0 - m : m;
  endfunction

  assign comp[0] = in_side.cx;
  assign comp[1] = in_side.cy;
  assign comp[2] = in_side.cz;

  // w = cos(theta/2) / 2^16, ties away from zero
  assign wv   = in_side.neg ? 32'sd0 - in_cs : in_cs;
  assign wmag = wv[31] ? 32'd0 - wv : wv;
  assign wsum = wmag + 32'd32768;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      pmag[l] = prod_q[l][47] ? 48'd0 - prod_q[l] : prod_q[l];
      // result is -(c*sn)/t, so a positive product gives a negative word
      pos[l]  = !prod_q[l][47] && (prod_q[l] != '0);
    end
    for (int s = 0; s < NW; s++) begin
      dv[s] = 48'(sided_q[s].t) << (NW - 1 - s);
      for (int l = 0; l < 3; l++) begin
        take[s][l] = rem_q[s][l] >= dv[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[D-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        prod_q[l] <= 48'(comp[l]) * 48'(in_sn);
      end
      w1_q    <= signed_out(wv[31], {1'b0, wsum[30:16]});
      side1_q <= in_side;

      for (int l = 0; l < 3; l++) begin
        rem_q[0][l] <= pmag[l] + 48'(side1_q.t[31:1]);
        quo_q[0][l] <= '0;
      end
      sgn_q[0]   <= pos;
      wq_q[0]    <= w1_q;
      sided_q[0] <= side1_q;

      for (int s = 0; s < NW; s++) begin
        for (int l = 0; l < 3; l++) begin
          rem_q[s+1][l] <= take[s][l] ? rem_q[s][l] - dv[s] : rem_q[s][l];
          quo_q[s+1][l] <= {quo_q[s][l][NW-2:0], take[s][l]};
        end
        sgn_q[s+1]   <= sgn_q[s];
        wq_q[s+1]    <= wq_q[s];
        sided_q[s+1] <= sided_q[s];
      end

      if (sided_q[NW].zero) begin
        quat_q <= '{w: aatq_pkg::OUT_MAX, default: '0};
      end else begin
        quat_q.w <= wq_q[NW];
        quat_q.x <= signed_out(sgn_q[NW][0], quo_q[NW][0]);
        quat_q.y <= signed_out(sgn_q[NW][1], quo_q[NW][1]);
        quat_q.z <= signed_out(sgn_q[NW][2], quo_q[NW][2]);
      end
    end
  end

  assign out_valid = v_q[D];
  assign out_quat  = quat_q;

endmodule

`default_nettype wire

FILE: rtl/core/axis_angle_to_quaternion.sv
// Top level: rotation vector stream in, conjugate unit quaternion stream out.
`default_nettype none

// Converts a rotation vector (axis times angle, Q3.13 radians per component) into
// the quaternion w = cos(theta/2), xyz = -c * sin(theta/2) / theta, all Q1.14,
// clamped to +/-16384; a zero vector gives the identity. One word is accepted
// per clock while the skid word is empty, and every word gives exactly one
// result word. The pipe is the 33-stage square root (one root bit per stage),
// the 3-stage range reduction, the 42-stage ten-term cos/sinc series (four
// stages per term around its 32x32 multipliers) and the 19-stage output
// divider (one quotient bit per stage), plus the output register. A two-word
// output buffer (output register plus one skid word) keeps the pipe moving
// while a result waits, until a second result lands in the skid; after that
// the whole pipe holds until the consumer takes a word.
module axis_angle_to_quaternion (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // rot_x [15:0], rot_y [31:16], rot_z [47:32]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
);

  logic             en;
  logic             sq_valid, pr_valid, se_valid, q_valid;
  aatq_pkg::side_t  sq_side, pr_side, se_side;
  logic signed [31:0] se_cs, se_sn;
  aatq_pkg::quat_t  q_quat;
  logic             o_valid, sk_valid;
  aatq_pkg::quat_t  o_q, sk_q;

  assign en            = !sk_valid;
  assign s_axis_tready = en;

  aatq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_x      (s_axis_tdata[15:0]),
    .in_y      (s_axis_tdata[31:16]),
    .in_z      (s_axis_tdata[47:32]),
    .out_valid (sq_valid),
    .out_side  (sq_side)
  );

  aatq_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .out_valid (pr_valid),
    .out_side  (pr_side)
  );

  aatq_series u_series (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pr_valid),
    .in_side   (pr_side),
    .out_valid (se_valid),
    .out_side  (se_side),
    .out_cs    (se_cs),
    .out_sn    (se_sn)
  );

  aatq_quot u_quot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (se_valid),
    .in_side   (se_side),
    .in_cs     (se_cs),
    .in_sn     (se_sn),
    .out_valid (q_valid),
    .out_quat  (q_quat)
  );

  // output word plus one skid word; the pipe only moves while the skid is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid  <= 1'b0;
      sk_valid <= 1'b0;
    end else if (!o_valid || m_axis_tready) begin
      o_valid  <= sk_valid || (en && q_valid);
      sk_valid <= 1'b0;
    end else if (en && q_valid) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || m_axis_tready) begin
      o_q <= sk_valid ? sk_q : q_quat;
    end else if (en) begin
      sk_q <= q_quat;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_q;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> o_valid)
    else $error("skid word held with empty output register");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    sk_valid && !m_axis_tready |=> sk_valid && $stable(sk_q))
    else $error("skid word lost or changed while output stalled");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sk_valid) |-> $past(o_valid && !m_axis_tready))
    else $error("skid filled while output register could take the word");

  a_w_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (o_q.w <= 16'sd16384) && (o_q.w >= -16'sd16384))
    else $error("quat_w outside clamp range");

endmodule

`default_nettype wire

FILE: tb/sv/axis_angle_to_quaternion_tb.sv
// Self-checking testbench for the rotation vector to conjugate quaternion stream block.
module axis_angle_to_quaternion_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q30_ONE      = 64'sd1073741824;
  localparam longint Q30_PI       = 64'sd3373259426;
  localparam longint Q30_HALF_PI  = 64'sd1686629713;
  localparam longint Q30_RND_HALF = 64'sd536870912;
  localparam longint QUAT_LIM     = 64'sd16384;
  localparam int     NUM_TERMS    = 10;
  localparam int     RANDOM_WORDS = 1050;
  localparam int     IDLE_LIMIT   = 4000;
  localparam int     DRAIN_CYCLES = 120;

  localparam aatq_pkg::quat_t IDENTITY = '{z: 16'sd0, y: 16'sd0, x: 16'sd0, w: 16'sd16384};

  typedef struct packed {
    logic [15:0]     x;
    logic [15:0]     y;
    logic [15:0]     z;
    logic            known;
    aatq_pkg::quat_t want;
  } rot_row_t;

  // known rows carry the result typed in; the rest go through the predictor
  localparam rot_row_t DIRECTED [24] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, IDENTITY},
    '{16'h7FFF, 16'h0000, 16'h0000, 1'b0, 64'd0},
    '{16'h8000, 16'h0000, 16'h0000, 1'b0, 64'd0},
    '{16'h0000, 16'h7FFF, 16'h0000, 1'b0, 64'd0},
    '{16'h0000, 16'h8000, 16'h0000, 1'b0, 64'd0},
    '{16'h0000, 16'h0000, 16'h7FFF, 1'b0, 64'd0},
    '{16'h0000, 16'h0000, 16'h8000, 1'b0, 64'd0},
    '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 64'd0},
    '{16'h8000, 16'h8000, 16'h8000, 1'b0, 64'd0},   // longest vector, half angle past pi
    '{16'h0001, 16'h0000, 16'h0000, 1'b0, 64'd0},
    '{16'hFFFF, 16'h0000, 16'h0000, 1'b0, 64'd0},
    '{16'h0000, 16'h0000, 16'hFFFF, 1'b0, 64'd0},
    '{16'h0001, 16'h0001, 16'h0001, 1'b0, 64'd0},
    '{16'h6488, 16'h0000, 16'h0000, 1'b0, 64'd0},   // theta near pi: reduction edge
    '{16'h6489, 16'h0000, 16'h0000, 1'b0, 64'd0},
    '{16'h0000, 16'h9B78, 16'h0000, 1'b0, 64'd0},
    '{16'h7415, 16'h7415, 16'h7415, 1'b0, 64'd0},   // theta near 2 pi
    '{16'h8BEB, 16'h7415, 16'h8BEB, 1'b0, 64'd0},
    '{16'h3244, 16'h0000, 16'h0000, 1'b0, 64'd0},
    '{16'h1000, 16'hE000, 16'h0800, 1'b0, 64'd0},
    '{16'hB1E0, 16'h3A98, 16'hD8F0, 1'b0, 64'd0},
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, IDENTITY},
    '{16'h8000, 16'h7FFF, 16'h8000, 1'b0, 64'd0},
    '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, 64'd0}
  };

  typedef enum {RX_FREE, RX_COIN, RX_CHOKE, RX_ALTERNATE} rx_mode_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [63:0] m_axis_tdata;

  aatq_pkg::quat_t quat_pending[$];    // words presented, not yet taken
  aatq_pkg::quat_t quat_inflight[$];   // words taken, result not yet seen
  aatq_pkg::quat_t got_quat;
  aatq_pkg::quat_t want_quat;
  int       errors      = 0;
  int       words_out   = 0;
  int       idle_cycles = 0;
  int       burst_left  = 0;
  int       mode_left   = 0;
  rx_mode_t rx_mode     = RX_FREE;

  axis_angle_to_quaternion uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // v * 2^-30, nearest, ties away from zero
  function automatic longint rnd_q30(input longint v);
    if (v >= 0) return (v + Q30_RND_HALF) >>> 30;
    return -((-v + Q30_RND_HALF) >>> 30);
  endfunction

  function automatic longint div_nearest(input longint num, input longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic logic [15:0] clamp_q14(input longint v);
    if (v > QUAT_LIM) return 16'(QUAT_LIM);
    if (v < -QUAT_LIM) return 16'(-QUAT_LIM);
    return v[15:0];
  endfunction

  function automatic aatq_pkg::quat_t rotvec_to_quat(input logic [47:0] rot);
    logic signed [15:0] comp16 [3];
    longint             comp [3];
    longint unsigned    rem, root, probe;
    longint             theta, hr, u, cs, sc, sn;
    logic               flip;
    int                 k, i;
    aatq_pkg::quat_t    q;
    comp16[0] = rot[15:0];
    comp16[1] = rot[31:16];
    comp16[2] = rot[47:32];
    for (i = 0; i < 3; i++) comp[i] = comp16[i];
    rem = comp[0] * comp[0] + comp[1] * comp[1] + comp[2] * comp[2];
    if (rem == 0) return IDENTITY;
    // theta in units of 2^-29 by bitwise integer square root
    rem = rem << 32;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    theta = longint'(root);
    hr = theta;
    flip = 1'b0;
    if (hr > Q30_HALF_PI) begin
      hr = Q30_PI - hr;
      flip = 1'b1;
    end
    u = rnd_q30(hr * hr);
    cs = Q30_ONE;
    sc = Q30_ONE;
    for (k = NUM_TERMS; k >= 1; k--) begin
      cs = Q30_ONE - rnd_q30(cs * u) / longint'((2 * k - 1) * (2 * k));
      sc = Q30_ONE - rnd_q30(sc * u) / longint'((2 * k) * (2 * k + 1));
    end
    sn = rnd_q30(sc * hr);
    q.w = clamp_q14(div_nearest(flip ? -cs : cs, 65536));
    q.x = clamp_q14(div_nearest(-(comp[0] * sn), theta));
    q.y = clamp_q14(div_nearest(-(comp[1] * sn), theta));
    q.z = clamp_q14(div_nearest(-(comp[2] * sn), theta));
    return q;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // bursts of random length, random gaps between them, some bursts back to back
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 48'({$urandom, $urandom});
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_rot(input logic [47:0] rot, input aatq_pkg::quat_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rot;
    quat_pending.insert(quat_pending.size(), want);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  initial begin
    int          n, pick, j;
    logic [15:0] comp [3];
    logic [47:0] rot;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < $size(DIRECTED); n++) begin
      rot = {DIRECTED[n].z, DIRECTED[n].y, DIRECTED[n].x};
      pace();
      send_rot(rot, DIRECTED[n].known ? DIRECTED[n].want : rotvec_to_quat(rot));
    end

    for (n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      for (j = 0; j < 3; j++) begin
        if (pick < 35) begin
          comp[j] = 16'($urandom);
        end else if (pick < 60) begin
          comp[j] = 16'($urandom_range(0, 511) - 256);
        end else if (pick < 70) begin
          comp[j] = (j == pick % 3) ? 16'($urandom) : 16'h0000;
        end else if (pick < 82) begin
          // long vectors: half angle beyond pi/2
          comp[j] = 16'($urandom_range(20000, 32767));
          if ($urandom_range(0, 1) != 0) comp[j] = -comp[j];
        end else if (pick < 88) begin
          comp[j] = 16'($urandom_range(0, 6) - 3);
        end else if (pick < 92) begin
          comp[j] = 16'h0000;
        end else begin
          comp[j] = (j == pick % 3) ? (pick[0] ? 16'h8000 : 16'h7FFF) : 16'($urandom);
        end
      end
      rot = {comp[2], comp[1], comp[0]};
      pace();
      send_rot(rot, rotvec_to_quat(rot));
    end
    s_axis_tvalid <= 1'b0;

    while (quat_pending.size() != 0 || quat_inflight.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver stalls: phases of free flow, coin toss, heavy choke and alternation
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 300);
    end
    mode_left--;
    case (rx_mode)
      RX_FREE:  m_axis_tready <= 1'b1;
      RX_COIN:  m_axis_tready <= ($urandom_range(0, 1) != 0);
      RX_CHOKE: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:  m_axis_tready <= ~m_axis_tready;
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready && quat_pending.size() != 0) begin
        quat_inflight.insert(quat_inflight.size(), quat_pending.pop_front());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_quat = m_axis_tdata;
        if (quat_inflight.size() == 0) begin
          note_error($sformatf("word %0d: result with none outstanding, w=%0d x=%0d y=%0d z=%0d",
                               words_out, got_quat.w, got_quat.x, got_quat.y, got_quat.z));
        end else begin
          want_quat = quat_inflight.pop_front();
          if (got_quat.w !== want_quat.w || got_quat.x !== want_quat.x ||
              got_quat.y !== want_quat.y || got_quat.z !== want_quat.z) begin
            note_error($sformatf(
              "word %0d mismatch: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
              words_out, want_quat.w, want_quat.x, want_quat.y, want_quat.z,
              got_quat.w, got_quat.x, got_quat.y, got_quat.z));
          end
        end
        words_out++;
      end
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
